// ===== hw/rtl/raqt_pkg.sv =====
// Shared types and constants for the reader anomaly quarantine table.
// No dependencies; imported by raqt_front, raqt_back and the top level.
package raqt_pkg;

  localparam int OPC_W      = 3;
  localparam int RID_W      = 8;
  localparam int SEQ_W      = 64;
  localparam int TS_W       = 48;
  localparam int THR_W      = 32;
  localparam int LIM_W      = 8;
  localparam int STREAK_W   = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_ROLLBACK_THR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAIL_LIMIT   = 1'b1;

  localparam logic [THR_W-1:0]    ROLLBACK_THR_RST = '0;
  localparam logic [LIM_W-1:0]    FAIL_LIMIT_RST   = 8'd5;
  localparam logic [STREAK_W-1:0] STREAK_MAX       = '1;

  typedef enum logic [OPC_W-1:0] {
    OP_SEQ      = 3'd0,
    OP_SUCCESS  = 3'd1,
    OP_TAG_FAIL = 3'd2,
    OP_NONCE    = 3'd3,
    OP_REPLAY   = 3'd4,
    OP_UNQUAR   = 3'd5,
    OP_QUERY    = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    KIND_REUSE    = 2'd0,
    KIND_ROLLBACK = 2'd1,
    KIND_NONCE    = 2'd2,
    KIND_STREAK   = 2'd3
  } kind_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } st_t;

  // classified event handed from the front to the back
  typedef struct packed {
    op_t              op;
    logic             hit;    // reader id inside the table
    logic [RID_W-1:0] rid;
    logic [SEQ_W-1:0] seq;
    logic [TS_W-1:0]  ts;
  } cmd_t;

  // one table entry
  typedef struct packed {
    logic [SEQ_W-1:0]    hseq;
    logic [STREAK_W-1:0] streak;
    logic                qflag;
    kind_t               qkind;
    logic [TS_W-1:0]     qstamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic            anomaly;
    kind_t           kind;
    logic            cleared;
    logic            quar;
    kind_t           reason;
    logic [TS_W-1:0] qtime;
  } result_t;

  typedef struct packed {
    logic [THR_W-1:0] thr;
    logic [LIM_W-1:0] limit;
  } cfg_t;

endpackage

// ===== hw/rtl/raqt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module raqt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// ===== hw/rtl/raqt_front.sv =====
// Front end: accepts events, classifies them and queues them for the back end.
// Depends on raqt_pkg.
module raqt_front import raqt_pkg::*; #(
  parameter int READERS = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  logic [OPC_W-1:0] in_opcode,
  input  logic [RID_W-1:0] in_reader_id,
  input  logic [SEQ_W-1:0] in_sequence_number,
  input  logic [TS_W-1:0]  in_timestamp_ms,
  output logic             cmd_valid,
  output cmd_t             cmd,
  input  logic             cmd_take
);

  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       cls;
  logic       acc;

  // opcode 7 behaves as a query
  always_comb begin
    cls.rid = in_reader_id;
    cls.seq = in_sequence_number;
    cls.ts  = in_timestamp_ms;
    cls.hit = (32'(in_reader_id) < READERS);
    case (in_opcode)
      OP_SEQ:      cls.op = OP_SEQ;
      OP_SUCCESS:  cls.op = OP_SUCCESS;
      OP_TAG_FAIL: cls.op = OP_TAG_FAIL;
      OP_NONCE:    cls.op = OP_NONCE;
      OP_REPLAY:   cls.op = OP_REPLAY;
      OP_UNQUAR:   cls.op = OP_UNQUAR;
      default:     cls.op = OP_QUERY;
    endcase
  end

  assign full      = (cnt_r == 2'd2);
  assign acc       = push && !full;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ acc;
    rd_ptr_nxt = rd_ptr_r ^ cmd_take;
    cnt_nxt    = cnt_r + {1'b0, acc} - {1'b0, cmd_take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// ===== hw/rtl/raqt_back.sv =====
// Back end: table read-modify-write sequencer and result queue.
// Depends on raqt_pkg and raqt_ram.
module raqt_back import raqt_pkg::*; #(
  parameter int READERS = 256
) (
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    cmd_valid,
  input  cmd_t    cmd,
  output logic    cmd_take,
  output logic    empty,
  input  logic    pop,
  output result_t res
);

  localparam int DEPTH = (READERS < 256) ? READERS : 256;
  localparam int AW    = $clog2(DEPTH);

  st_t          st_r, st_nxt;
  cmd_t         cur_r;
  logic [DEPTH-1:0] vld_r;
  logic [ENTRY_W-1:0] rdata;
  logic [AW-1:0] cur_idx;
  entry_t       ent, ent_n;
  result_t      rslt;
  logic         wr_en;
  logic         anomaly;
  kind_t        kind;
  logic         cleared;
  logic [SEQ_W:0] sum;
  logic         rollback;
  logic [STREAK_W-1:0] streak_inc;

  result_t    rq_r [2];
  logic       rq_wr_r, rq_wr_nxt;
  logic       rq_rd_r, rq_rd_nxt;
  logic [1:0] rq_cnt_r, rq_cnt_nxt;
  logic       rq_push, rq_pop;

  assign cur_idx = cur_r.rid[AW-1:0];

  raqt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_tbl (
    .clk  (clk),
    .we   (wr_en),
    .waddr(cur_idx),
    .wdata(ent_n),
    .re   (cmd_take),
    .raddr(cmd.rid[AW-1:0]),
    .rdata(rdata)
  );

  // an entry never written since reset reads as zero
  assign ent        = vld_r[cur_idx] ? entry_t'(rdata) : '0;
  assign sum        = {1'b0, cur_r.seq} + {{(SEQ_W + 1 - THR_W){1'b0}}, cfg.thr};
  assign rollback   = (ent.hseq != '0) && (sum < {1'b0, ent.hseq});
  assign streak_inc = (ent.streak == STREAK_MAX) ? ent.streak : ent.streak + 1'b1;

  always_comb begin
    st_nxt   = st_r;
    cmd_take = 1'b0;
    wr_en    = 1'b0;
    rq_push  = 1'b0;
    ent_n    = ent;
    anomaly  = 1'b0;
    kind     = KIND_REUSE;
    cleared  = 1'b0;
    case (op_t'(cur_r.op))
      OP_SEQ: begin
        if (rollback) begin
          anomaly = 1'b1;
          kind    = KIND_ROLLBACK;
        end else if (cur_r.seq > ent.hseq) begin
          ent_n.hseq = cur_r.seq;
        end
      end
      OP_SUCCESS: begin
        ent_n.streak = '0;
        if (cur_r.seq > ent.hseq) begin
          ent_n.hseq = cur_r.seq;
        end
      end
      OP_TAG_FAIL: begin
        ent_n.streak = streak_inc;
        if (streak_inc >= cfg.limit) begin
          anomaly = 1'b1;
          kind    = KIND_STREAK;
        end
      end
      OP_NONCE: begin
        anomaly = 1'b1;
        kind    = KIND_NONCE;
      end
      OP_REPLAY: begin
        anomaly = 1'b1;
        kind    = KIND_REUSE;
      end
      OP_UNQUAR: begin
        if (ent.qflag) begin
          cleared      = 1'b1;
          ent_n.qflag  = 1'b0;
          ent_n.qkind  = KIND_REUSE;
          ent_n.qstamp = '0;
          ent_n.streak = '0;
        end
      end
      default: ;
    endcase
    if (anomaly) begin
      ent_n.qflag  = 1'b1;
      ent_n.qkind  = kind;
      ent_n.qstamp = cur_r.ts;
    end

    rslt.anomaly = anomaly;
    rslt.kind    = kind;
    rslt.cleared = cleared;
    rslt.quar    = ent_n.qflag;
    rslt.reason  = ent_n.qflag ? ent_n.qkind : KIND_REUSE;
    rslt.qtime   = ent_n.qflag ? ent_n.qstamp : '0;
    if (!cur_r.hit) begin
      rslt = '0;
    end

    case (st_r)
      ST_IDLE: begin
        // room for the result is reserved before the event is taken
        if (cmd_valid && rq_cnt_r != 2'd2) begin
          cmd_take = 1'b1;
          st_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        wr_en   = cur_r.hit;
        rq_push = 1'b1;
        st_nxt  = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      vld_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (wr_en) begin
        vld_r[cur_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      cur_r <= cmd;
    end
  end

  // result queue
  assign empty  = (rq_cnt_r == 2'd0);
  assign rq_pop = pop && !empty;
  assign res    = rq_r[rq_rd_r];

  always_comb begin
    rq_wr_nxt  = rq_wr_r ^ rq_push;
    rq_rd_nxt  = rq_rd_r ^ rq_pop;
    rq_cnt_nxt = rq_cnt_r + {1'b0, rq_push} - {1'b0, rq_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rq_wr_r  <= 1'b0;
      rq_rd_r  <= 1'b0;
      rq_cnt_r <= 2'd0;
    end else begin
      rq_wr_r  <= rq_wr_nxt;
      rq_rd_r  <= rq_rd_nxt;
      rq_cnt_r <= rq_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rq_push) begin
      rq_r[rq_wr_r] <= rslt;
    end
  end

  a_rq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rq_cnt_r != 2'd3)
    else $error("result queue count out of range");

  a_take_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_take |=> (st_r == ST_EXEC) && rq_push)
    else $error("taken event not executed next cycle");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    rq_push |-> (rq_cnt_r != 2'd2) || rq_pop)
    else $error("result pushed into full queue");

  a_wr_exec: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (st_r == ST_EXEC) && cur_r.hit)
    else $error("table write outside execute");

endmodule

// ===== hw/rtl/reader_anomaly_quarantine_table_unit.sv =====
// Top level of the reader anomaly quarantine table.
// Depends on raqt_pkg, raqt_front, raqt_back (and raqt_ram through raqt_back).
//
// Usage:
//   Events enter on the push/full queue port (in_* fields); one result word
//   per event leaves on the empty/pop queue port (out_* fields), in order.
//   Config registers are written through cfg_wr_en/cfg_index/cfg_data; the
//   user must write them only while the block is idle, which the block itself
//   does not enforce; index 0 is the rollback threshold, 1 the fail limit.
//   An event is written into the event queue, taken into the back end while
//   its table entry is read, then updated and written back as its result
//   enters the result queue; no new event is taken before that write-back.
//   A two-entry event queue and a two-entry result queue decouple the sides;
//   while pop is held low, events keep entering until both queues fill, then
//   full rises.
//   Reset (synchronous, rst_n low) empties both queues, restores the config
//   defaults and marks every table entry as zero through per-entry valid bits;
//   no clearing pass is needed. Reader ids at or above READERS answer zeros.
module reader_anomaly_quarantine_table_unit import raqt_pkg::*; #(
  parameter int READERS = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  logic [OPC_W-1:0]      in_opcode,
  input  logic [RID_W-1:0]      in_reader_id,
  input  logic [SEQ_W-1:0]      in_sequence_number,
  input  logic [TS_W-1:0]       in_timestamp_ms,
  output logic                  empty,
  input  logic                  pop,
  output logic                  out_anomaly_flag,
  output logic [1:0]            out_anomaly_kind,
  output logic                  out_cleared_flag,
  output logic                  out_quarantined,
  output logic [1:0]            out_quarantine_reason,
  output logic [TS_W-1:0]       out_quarantine_time,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg_r, cfg_nxt;
  logic    cmd_valid;
  logic    cmd_take;
  cmd_t    cmd;
  result_t res;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_ROLLBACK_THR: cfg_nxt.thr   = cfg_data[THR_W-1:0];
        CFG_FAIL_LIMIT:   cfg_nxt.limit = cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.thr   <= ROLLBACK_THR_RST;
      cfg_r.limit <= FAIL_LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  raqt_front #(
    .READERS(READERS)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_opcode         (in_opcode),
    .in_reader_id      (in_reader_id),
    .in_sequence_number(in_sequence_number),
    .in_timestamp_ms   (in_timestamp_ms),
    .cmd_valid         (cmd_valid),
    .cmd               (cmd),
    .cmd_take          (cmd_take)
  );

  raqt_back #(
    .READERS(READERS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_take (cmd_take),
    .empty    (empty),
    .pop      (pop),
    .res      (res)
  );

  assign out_anomaly_flag      = res.anomaly;
  assign out_anomaly_kind      = res.kind;
  assign out_cleared_flag      = res.cleared;
  assign out_quarantined       = res.quar;
  assign out_quarantine_reason = res.reason;
  assign out_quarantine_time   = res.qtime;

endmodule

// ===== verif/tb_reader_anomaly_quarantine_table_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for reader_anomaly_quarantine_table_unit.
// Needs raqt_pkg and the block's RTL. Events go in through a queue-fed driver and results
// are checked by a monitor against an in-bench model of the per-reader table.
module tb_reader_anomaly_quarantine_table_unit;
  import raqt_pkg::*;

  localparam int READERS      = 256;
  localparam int POOL_SIZE    = 6;
  localparam int LATENCY_WAIT = 8;
  localparam int STALL_LIMIT  = 2000;
  localparam int PRINT_LIMIT  = 40;

  // opcode 7 has no operation of its own and acts as a query
  localparam logic [OPC_W-1:0] OPC_UNUSED = 3'd7;

  typedef struct packed {
    logic [OPC_W-1:0] opcode;
    logic [RID_W-1:0] rid;
    logic [SEQ_W-1:0] seq;
    logic [TS_W-1:0]  ts;
  } reader_event_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  push = 1'b0;
  logic                  full;
  logic [OPC_W-1:0]      in_opcode = '0;
  logic [RID_W-1:0]      in_reader_id = '0;
  logic [SEQ_W-1:0]      in_sequence_number = '0;
  logic [TS_W-1:0]       in_timestamp_ms = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic                  out_anomaly_flag;
  logic [1:0]            out_anomaly_kind;
  logic                  out_cleared_flag;
  logic                  out_quarantined;
  logic [1:0]            out_quarantine_reason;
  logic [TS_W-1:0]       out_quarantine_time;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_ROLLBACK_THR;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  reader_anomaly_quarantine_table_unit #(.READERS(READERS)) u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .push                 (push),
    .full                 (full),
    .in_opcode            (in_opcode),
    .in_reader_id         (in_reader_id),
    .in_sequence_number   (in_sequence_number),
    .in_timestamp_ms      (in_timestamp_ms),
    .empty                (empty),
    .pop                  (pop),
    .out_anomaly_flag     (out_anomaly_flag),
    .out_anomaly_kind     (out_anomaly_kind),
    .out_cleared_flag     (out_cleared_flag),
    .out_quarantined      (out_quarantined),
    .out_quarantine_reason(out_quarantine_reason),
    .out_quarantine_time  (out_quarantine_time),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  always #5 clk = ~clk;

  // model copy of the config and the table
  logic [THR_W-1:0]    rollback_thr = ROLLBACK_THR_RST;
  logic [LIM_W-1:0]    fail_limit   = FAIL_LIMIT_RST;
  logic [SEQ_W-1:0]    hseq_tab   [READERS] = '{default: '0};
  logic [STREAK_W-1:0] streak_tab [READERS] = '{default: '0};
  logic                qflag_tab  [READERS] = '{default: 1'b0};
  kind_t               qkind_tab  [READERS] = '{default: KIND_REUSE};
  logic [TS_W-1:0]     qstamp_tab [READERS] = '{default: '0};

  // stimulus side: rough view of each reader's highest sequence, to aim near the
  // rollback boundary
  logic [SEQ_W-1:0] seq_hint    [READERS] = '{default: '0};
  logic [RID_W-1:0] reader_pool [POOL_SIZE];

  reader_event_t pending_q [$];
  result_t       expected_q [$];
  reader_event_t cur_event;

  int unsigned queued_cnt    = 0;
  int unsigned accepted_cnt  = 0;
  int unsigned mismatch_cnt  = 0;
  int unsigned stall_cycles  = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  function automatic void mark_quarantine(int unsigned r, kind_t why, logic [TS_W-1:0] stamp);
    qflag_tab[r]  = 1'b1;
    qkind_tab[r]  = why;
    qstamp_tab[r] = stamp;
  endfunction

  function automatic result_t quarantine_update(reader_event_t ev);
    result_t        res;
    logic [SEQ_W:0] reach;
    int unsigned    r;
    res = '0;
    r = ev.rid;
    case (ev.opcode)
      OP_SEQ: begin
        // sum kept one bit wider so it cannot wrap
        reach = {1'b0, ev.seq} + rollback_thr;
        if (hseq_tab[r] != '0 && reach < {1'b0, hseq_tab[r]}) begin
          res.anomaly = 1'b1;
          res.kind = KIND_ROLLBACK;
          mark_quarantine(r, KIND_ROLLBACK, ev.ts);
        end else if (ev.seq > hseq_tab[r]) begin
          hseq_tab[r] = ev.seq;
        end
      end
      OP_SUCCESS: begin
        streak_tab[r] = '0;
        if (ev.seq > hseq_tab[r]) hseq_tab[r] = ev.seq;
      end
      OP_TAG_FAIL: begin
        if (streak_tab[r] != STREAK_MAX) streak_tab[r] = streak_tab[r] + 1'b1;
        if (streak_tab[r] >= fail_limit) begin
          res.anomaly = 1'b1;
          res.kind = KIND_STREAK;
          mark_quarantine(r, KIND_STREAK, ev.ts);
        end
      end
      OP_NONCE: begin
        res.anomaly = 1'b1;
        res.kind = KIND_NONCE;
        mark_quarantine(r, KIND_NONCE, ev.ts);
      end
      OP_REPLAY: begin
        res.anomaly = 1'b1;
        res.kind = KIND_REUSE;
        mark_quarantine(r, KIND_REUSE, ev.ts);
      end
      OP_UNQUAR: begin
        if (qflag_tab[r]) begin
          qflag_tab[r]  = 1'b0;
          qkind_tab[r]  = KIND_REUSE;
          qstamp_tab[r] = '0;
          streak_tab[r] = '0;
          res.cleared = 1'b1;
        end
      end
      default: ;
    endcase
    res.quar = qflag_tab[r];
    if (qflag_tab[r]) begin
      res.reason = qkind_tab[r];
      res.qtime  = qstamp_tab[r];
    end
    return res;
  endfunction

  task automatic flag_mismatch(string what);
    mismatch_cnt++;
    if (mismatch_cnt <= PRINT_LIMIT) $display("[%0t] MISMATCH %s", $time, what);
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) flag_mismatch($sformatf("%s: got %0h, expected %0h", name, got, want));
  endtask

  task automatic queue_event(logic [OPC_W-1:0] op, logic [RID_W-1:0] rid,
                             logic [SEQ_W-1:0] seq, logic [TS_W-1:0] ts);
    pending_q.push_back('{opcode: op, rid: rid, seq: seq, ts: ts});
    queued_cnt++;
  endtask

  task automatic add_random_event();
    logic [OPC_W-1:0] op;
    logic [RID_W-1:0] rid;
    logic [SEQ_W-1:0] seq;
    logic [SEQ_W-1:0] base;
    int unsigned      pick;
    if ($urandom_range(99) < 85) rid = reader_pool[$urandom_range(POOL_SIZE - 1)];
    else rid = RID_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 25)      op = OP_SEQ;
    else if (pick < 35) op = OP_SUCCESS;
    else if (pick < 60) op = OP_TAG_FAIL;
    else if (pick < 65) op = OP_NONCE;
    else if (pick < 70) op = OP_REPLAY;
    else if (pick < 83) op = OP_UNQUAR;
    else if (pick < 93) op = OP_QUERY;
    else                op = OPC_UNUSED;
    base = seq_hint[rid];
    pick = $urandom_range(99);
    if (pick < 45)      seq = base + $urandom_range(16);
    else if (pick < 80) seq = base - rollback_thr - $urandom_range(2);  // straddle the boundary
    else if (pick < 95) seq = {$urandom, $urandom};
    else if (pick < 98) seq = '1;
    else                seq = '0;
    if ((op == OP_SEQ || op == OP_SUCCESS) && seq > base) seq_hint[rid] = seq;
    queue_event(op, rid, seq, TS_W'({$urandom, $urandom}));
  endtask

  task automatic drain();
    do @(posedge clk); while (accepted_cnt != queued_cnt || expected_q.size() != 0);
    repeat (LATENCY_WAIT) @(posedge clk);
  endtask

  task automatic write_config(logic [THR_W-1:0] thr, logic [LIM_W-1:0] lim);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_ROLLBACK_THR;
    cfg_data  <= thr;
    @(posedge clk);
    cfg_index <= CFG_FAIL_LIMIT;
    cfg_data  <= {{(CFG_DATA_W - LIM_W){1'b0}}, lim};
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    rollback_thr = thr;
    fail_limit   = lim;
  endtask

  task automatic run_phase(int unsigned send_pct, int unsigned recv_pct,
                           logic [THR_W-1:0] thr, logic [LIM_W-1:0] lim,
                           int unsigned n_random, int unsigned n_streak);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    write_config(thr, lim);
    foreach (reader_pool[i]) reader_pool[i] = RID_W'($urandom);
    // long tag-failure run on one reader drives the streak into saturation
    repeat (n_streak) queue_event(OP_TAG_FAIL, reader_pool[0], {$urandom, $urandom},
                                  TS_W'({$urandom, $urandom}));
    repeat (n_random) add_random_event();
    drain();
  endtask

  always @(posedge clk) begin : driver
    logic take;
    take = 1'b0;
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        expected_q.push_back(quarantine_update(cur_event));
        accepted_cnt++;
      end
      if (!push || !full) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) take = 1'b1;
        if (take) begin
          cur_event = pending_q.pop_front();
          in_opcode          <= cur_event.opcode;
          in_reader_id       <= cur_event.rid;
          in_sequence_number <= cur_event.seq;
          in_timestamp_ms    <= cur_event.ts;
        end
        push <= take;
      end
    end
  end

  always @(posedge clk) begin : monitor
    result_t want;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_q.size() == 0) begin
          flag_mismatch("result word with nothing expected");
        end else begin
          want = expected_q.pop_front();
          check_field("anomaly_flag", out_anomaly_flag, want.anomaly);
          check_field("anomaly_kind", out_anomaly_kind, want.kind);
          check_field("cleared_flag", out_cleared_flag, want.cleared);
          check_field("quarantined", out_quarantined, want.quar);
          check_field("quarantine_reason", out_quarantine_reason, want.reason);
          check_field("quarantine_time", out_quarantine_time, want.qtime);
        end
      end
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("[%0t] no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed words at the reset config: threshold 0, streak limit 5
    send_idle_pct = 27;
    recv_idle_pct = 73;
    queue_event(OP_QUERY, 8'd0, '0, '0);
    queue_event(OP_SEQ, 8'd0, '0, '0);
    queue_event(OP_SEQ, 8'd0, '1, '1);
    queue_event(OP_SEQ, 8'd0, '0, '1);          // rollback from the top
    queue_event(OP_SEQ, 8'd0, '1, '0);          // equal to highest, no anomaly
    queue_event(OP_UNQUAR, 8'd0, '0, '0);
    queue_event(OP_UNQUAR, 8'd0, '0, '0);       // nothing left to clear
    queue_event(OP_REPLAY, 8'hFF, '1, '0);
    queue_event(OP_NONCE, 8'hFF, '0, 48'h5A5A_A5A5_5A5A);  // overwrites reason and stamp
    queue_event(OP_SUCCESS, 8'd1, 64'h8000_0000_0000_0000, '0);
    queue_event(OP_SEQ, 8'd1, 64'h7FFF_FFFF_FFFF_FFFF, 48'd123);
    for (int i = 1; i <= 6; i++) queue_event(OP_TAG_FAIL, 8'd2, '0, TS_W'(i));
    queue_event(OP_SUCCESS, 8'd2, 64'd3, '0);
    queue_event(OPC_UNUSED, 8'd2, '1, '1);
    queue_event(OP_UNQUAR, 8'd2, '0, '0);
    queue_event(OP_SEQ, 8'd3, 64'd10, '0);
    queue_event(OP_SEQ, 8'd3, 64'd10, '0);
    queue_event(OP_SEQ, 8'd3, 64'd9, 48'hFFFF_0000_FFFF);
    drain();

    run_phase(27, 73, '0, '0, 180, 0);
    run_phase(27, 73, 32'd16, 8'd3, 180, 0);
    run_phase(73, 27, '1, '1, 70, 260);
    run_phase(73, 27, $urandom, 8'd1, 180, 0);
    run_phase(0, 0, 32'd5, 8'd5, 180, 0);
    run_phase(0, 0, $urandom_range(100), LIM_W'($urandom_range(8, 2)), 180, 0);

    if (mismatch_cnt == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/raqt_pkg.sv
hw/rtl/raqt_ram.sv
hw/rtl/raqt_front.sv
hw/rtl/raqt_back.sv
hw/rtl/reader_anomaly_quarantine_table_unit.sv
verif/tb_reader_anomaly_quarantine_table_unit.sv
